// File: hw/rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared widths, parse phase codes and the result record type.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int OPC_W   = 4;
    localparam int LEN_W   = 63;
    localparam int KEY_W   = 32;
    localparam int HDRC_W  = 4;
    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HDR0   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [HDRC_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [HDRC_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [HDRC_W-1:0] KEY_BYTES   = 4'd4;

    localparam logic [OPC_W-1:0] OPC_CONT      = 4'd0;
    localparam logic [OPC_W-1:0] OPC_FIRST_CTL = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic [OPC_W-1:0]  message_type;
        logic              frame_fin;
        logic              frame_end;
    } wsd_result_t;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a received byte stream and emits unmasked,
// tagged payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received stream byte per transfer (s_rx_byte).
//   m_ channel: one result per payload byte, or a single result with
//   m_has_data low for an empty frame. Header bytes give no result.
//   Each result carries the effective message type (continuation frames take
//   the last data opcode), the frame's FIN bit and an end-of-frame mark.
//   Each accepted byte updates the parse state and registers any result.
//   Throughput: one byte per cycle while s_ready is high.
//   Stall: a result register plus one skid entry keep s_ready high while one
//   result waits; s_ready drops only when two results are waiting.
//   Reset: synchronous, active low; the parser waits for the first header
//   byte, the remembered message type is cleared and both result slots empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wsd_pkg::BYTE_W-1:0] m_payload_byte,
    output logic                       m_has_data,
    output logic [wsd_pkg::OPC_W-1:0]  m_message_type,
    output logic                       m_frame_fin,
    output logic                       m_frame_end
);
    import wsd_pkg::*;

    logic        byte_accept;
    logic        res_valid;
    wsd_result_t res;
    wsd_result_t out_res;

    assign byte_accept = s_valid && s_ready;

    wsd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_accept && res_valid),
        .push_data (res),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_res)
    );

    assign m_payload_byte = out_res.payload_byte;
    assign m_has_data     = out_res.has_data;
    assign m_message_type = out_res.message_type;
    assign m_frame_fin    = out_res.frame_fin;
    assign m_frame_end    = out_res.frame_end;

endmodule

// File: hw/rtl/wsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame parse state and turns each received byte into at most one
// tagged, unmasked payload result.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_accept,
    input  logic [wsd_pkg::BYTE_W-1:0] rx_byte,
    output logic                      res_valid,
    output wsd_pkg::wsd_result_t      res
);
    import wsd_pkg::*;

    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [HDRC_W-1:0]  hdr_left_reg,   hdr_left_next;
    logic               fin_reg,        fin_next;
    logic [OPC_W-1:0]   opcode_reg,     opcode_next;
    logic               masked_reg,     masked_next;
    logic [LEN_W-1:0]   len_left_reg,   len_left_next;
    logic [KEY_W-1:0]   key_reg,        key_next;
    logic [1:0]         key_idx_reg,    key_idx_next;
    logic [OPC_W-1:0]   data_type_reg,  data_type_next;

    logic [HDRC_W-1:0]  hdr_dec;
    logic [LEN_W-1:0]   len_shift;
    logic [6:0]         len7;
    logic [BYTE_W-1:0]  key_byte;
    logic [OPC_W-1:0]   eff_type;

    assign hdr_dec   = hdr_left_reg - 4'd1;
    assign len_shift = {len_left_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign len7      = rx_byte[6:0];
    assign eff_type  = (opcode_reg == OPC_CONT) ? data_type_reg : opcode_reg;

    always_comb begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        hdr_left_next  = hdr_left_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        len_left_next  = len_left_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        data_type_next = data_type_reg;
        res_valid      = 1'b0;
        res.payload_byte = '0;
        res.has_data     = 1'b0;
        res.message_type = eff_type;
        res.frame_fin    = fin_reg;
        res.frame_end    = 1'b1;

        unique case (phase_reg)
            PH_HDR1: begin
                masked_next = rx_byte[7];
                if (len7 == LEN7_EXT16) begin
                    len_left_next = '0;
                    hdr_left_next = EXT16_BYTES;
                    phase_next    = PH_EXTLEN;
                end else if (len7 == LEN7_EXT64) begin
                    len_left_next = '0;
                    hdr_left_next = EXT64_BYTES;
                    phase_next    = PH_EXTLEN;
                end else begin
                    len_left_next = {{(LEN_W-7){1'b0}}, len7};
                    key_idx_next  = '0;
                    key_next      = '0;
                    if (rx_byte[7]) begin
                        hdr_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end else if (len7 == 7'd0) begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_EXTLEN: begin
                // Shifting into a 63-bit register drops the top length bit.
                len_left_next = len_shift;
                hdr_left_next = hdr_dec;
                if (hdr_dec == '0) begin
                    key_idx_next = '0;
                    key_next     = '0;
                    if (masked_reg) begin
                        hdr_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end else if (len_shift == '0) begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_KEY: begin
                key_next      = {key_reg[KEY_W-BYTE_W-1:0], rx_byte};
                hdr_left_next = hdr_dec;
                if (hdr_dec == '0) begin
                    key_idx_next = '0;
                    if (len_left_reg == '0) begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                key_idx_next     = key_idx_reg + 2'd1;
                len_left_next    = len_left_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                res_valid        = 1'b1;
                res.payload_byte = rx_byte ^ (masked_reg ? key_byte : '0);
                res.has_data     = 1'b1;
                // The length never reaches zero here, so the last byte is at one.
                res.frame_end    = (len_left_reg == {{(LEN_W-1){1'b0}}, 1'b1});
                if (res.frame_end) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                if (rx_byte[3:0] != OPC_CONT && rx_byte[3:0] < OPC_FIRST_CTL) begin
                    data_type_next = rx_byte[3:0];
                end
                phase_next = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            hdr_left_reg  <= '0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            masked_reg    <= 1'b0;
            len_left_reg  <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
            data_type_reg <= '0;
        end else if (byte_accept) begin
            phase_reg     <= phase_next;
            hdr_left_reg  <= hdr_left_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            masked_reg    <= masked_next;
            len_left_reg  <= len_left_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
            data_type_reg <= data_type_next;
        end
    end

endmodule

// File: hw/rtl/wsd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer output buffer
// Result register with a skid stage, so the input side is never held off by
// a stalled receiver until two results are waiting.
// ----------------------------------------------------------------------------
module wsd_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  wsd_pkg::wsd_result_t push_data,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wsd_pkg::wsd_result_t m_data
);
    import wsd_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    wsd_result_t main_reg;
    wsd_result_t skid_reg;

    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!main_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        if (push && main_valid_reg && !m_ready) begin
            skid_reg <= push_data;
        end
    end

endmodule

// File: sim/wsd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer stream checker
// Watches both channels of the deframer, parses the accepted byte stream
// with its own frame parser and compares every result transfer, field by
// field, with the oldest expected payload result.
// ----------------------------------------------------------------------------
module wsd_stream_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] m_payload_byte,
    input  logic                       m_has_data,
    input  logic [wsd_pkg::OPC_W-1:0]  m_message_type,
    input  logic                       m_frame_fin,
    input  logic                       m_frame_end,
    output int                         mismatch_count,
    output int                         results_pending
);

    import wsd_pkg::*;

    logic [PHASE_W-1:0] parse_at;
    logic [HDRC_W-1:0]  hdr_left;
    logic               cur_fin;
    logic [OPC_W-1:0]   cur_opcode;
    logic               cur_masked;
    logic [LEN_W-1:0]   bytes_left;
    logic [KEY_W-1:0]   key_word;
    logic [1:0]         key_pos;
    logic [OPC_W-1:0]   last_data_type;

    wsd_result_t expected_payload_q[$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic push_result(input logic [BYTE_W-1:0] data, input logic has,
                               input logic last);
        wsd_result_t r;
        r.payload_byte = data;
        r.has_data     = has;
        // Continuation frames carry the type of the last data frame.
        r.message_type = (cur_opcode == OPC_CONT) ? last_data_type : cur_opcode;
        r.frame_fin    = cur_fin;
        r.frame_end    = last;
        expected_payload_q.insert(expected_payload_q.size(), r);
    endtask

    task automatic length_known();
        key_pos  = '0;
        key_word = '0;
        if (cur_masked) begin
            hdr_left = KEY_BYTES;
            parse_at = PH_KEY;
        end else if (bytes_left == '0) begin
            parse_at = PH_HDR0;
            push_result('0, 1'b0, 1'b1);
        end else begin
            parse_at = PH_DATA;
        end
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] key_byte;
        case (parse_at)
            PH_HDR1: begin
                cur_masked = b[7];
                bytes_left = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    hdr_left = EXT16_BYTES;
                    parse_at = PH_EXTLEN;
                end else if (b[6:0] == LEN7_EXT64) begin
                    hdr_left = EXT64_BYTES;
                    parse_at = PH_EXTLEN;
                end else begin
                    bytes_left = {{(LEN_W-7){1'b0}}, b[6:0]};
                    length_known();
                end
            end
            PH_EXTLEN: begin
                // The 63-bit register drops the top bit of a 64-bit length.
                bytes_left = {bytes_left[LEN_W-9:0], b};
                hdr_left   = hdr_left - 4'd1;
                if (hdr_left == '0) begin
                    length_known();
                end
            end
            PH_KEY: begin
                key_word = {key_word[KEY_W-9:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == '0) begin
                    key_pos = '0;
                    if (bytes_left == '0) begin
                        parse_at = PH_HDR0;
                        push_result('0, 1'b0, 1'b1);
                    end else begin
                        parse_at = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                key_byte = '0;
                if (cur_masked) begin
                    key_byte = key_word[8*(3-int'(key_pos)) +: 8];
                end
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
                push_result(b ^ key_byte, 1'b1, bytes_left == '0);
                if (bytes_left == '0) begin
                    parse_at = PH_HDR0;
                end
            end
            default: begin
                cur_fin    = b[7];
                cur_opcode = b[3:0];
                if (cur_opcode != OPC_CONT && cur_opcode < OPC_FIRST_CTL) begin
                    last_data_type = cur_opcode;
                end
                parse_at = PH_HDR1;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        wsd_result_t exp_r;
        if (!aresetn) begin
            parse_at       = PH_HDR0;
            hdr_left       = '0;
            cur_fin        = 1'b0;
            cur_opcode     = '0;
            cur_masked     = 1'b0;
            bytes_left     = '0;
            key_word       = '0;
            key_pos        = '0;
            last_data_type = '0;
            expected_payload_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                deframe_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_payload_q.size() == 0) begin
                    report_mismatch($sformatf("result %02h with none expected",
                                              m_payload_byte));
                end else begin
                    exp_r = expected_payload_q[0];
                    expected_payload_q.delete(0);
                    if (m_payload_byte !== exp_r.payload_byte) begin
                        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                                  m_payload_byte, exp_r.payload_byte));
                    end
                    if (m_has_data !== exp_r.has_data) begin
                        report_mismatch($sformatf("has_data %b, expected %b",
                                                  m_has_data, exp_r.has_data));
                    end
                    if (m_message_type !== exp_r.message_type) begin
                        report_mismatch($sformatf("message_type %h, expected %h",
                                                  m_message_type, exp_r.message_type));
                    end
                    if (m_frame_fin !== exp_r.frame_fin) begin
                        report_mismatch($sformatf("frame_fin %b, expected %b",
                                                  m_frame_fin, exp_r.frame_fin));
                    end
                    if (m_frame_end !== exp_r.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  m_frame_end, exp_r.frame_end));
                    end
                end
            end
        end
        results_pending <= expected_payload_q.size();
    end

endmodule

// File: sim/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds the deframer a byte stream of directed frames followed by random
// frames of every length encoding, with and without masks, under changing
// idle patterns and one long output stall; a separate checker predicts and
// compares the payload results.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    import wsd_pkg::*;

    localparam logic [OPC_W-1:0] OPC_BIN  = 4'h2;
    localparam logic [OPC_W-1:0] OPC_PING = 4'h9;
    localparam logic [OPC_W-1:0] OPC_PONG = 4'hA;

    localparam int BYTES_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 10;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [BYTE_W-1:0] m_payload_byte;
    logic              m_has_data;
    logic [OPC_W-1:0]  m_message_type;
    logic              m_frame_fin;
    logic              m_frame_end;

    int          mismatch_count;
    int          results_pending;
    int          sent_bytes    = 0;
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 59;
    logic        hold_armed    = 1'b0;
    logic        hold_done     = 1'b0;
    int          hold_count    = 0;

    websocket_frame_deframer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_has_data     (m_has_data),
        .m_message_type (m_message_type),
        .m_frame_fin    (m_frame_fin),
        .m_frame_end    (m_frame_end)
    );

    wsd_stream_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_has_data      (m_has_data),
        .m_message_type  (m_message_type),
        .m_frame_fin     (m_frame_fin),
        .m_frame_end     (m_frame_end),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Once armed, the receiver refuses results for a long stretch so that
    // both result slots fill and the input side has to stall.
    always @(posedge aclk) begin
        if (hold_armed && !hold_done) begin
            m_ready <= 1'b0;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
    endtask

    task automatic send_random_frame();
        logic [BYTE_W-1:0] head;
        logic              masked;
        logic [6:0]        len7;
        int                len_sel;
        int                plen;
        head = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) begin
            head[3:0] = OPC_CONT;
        end
        send_byte(head);
        masked  = 1'($urandom_range(0, 1));
        len_sel = $urandom_range(0, 99);
        if (len_sel < 70) begin
            plen = $urandom_range(0, 12);
            len7 = plen[6:0];
            send_byte({masked, len7});
        end else if (len_sel < 82) begin
            // Extended 16-bit length, deliberately non-minimal.
            plen = $urandom_range(0, 24);
            send_byte({masked, LEN7_EXT16});
            send_byte(plen[15:8]);
            send_byte(plen[7:0]);
        end else if (len_sel < 92) begin
            // Extended 64-bit length; the top bit is random and must be ignored.
            plen = $urandom_range(0, 24);
            send_byte({masked, LEN7_EXT64});
            send_byte({1'($urandom_range(0, 1)), 7'b0});
            repeat (6) send_byte(8'h00);
            send_byte(plen[7:0]);
        end else begin
            plen = $urandom_range(100, 125);
            len7 = plen[6:0];
            send_byte({masked, len7});
        end
        if (masked) begin
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        end
        repeat (plen) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Continuation before any data frame reports the cleared type.
        send_byte({1'b1, 3'b000, OPC_CONT});
        send_byte({1'b0, 7'd1});
        send_byte(8'hFF);
        // Masked empty ping: one result without data after the key.
        send_byte({1'b1, 3'b000, OPC_PING});
        send_byte({1'b1, 7'd0});
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        // Binary frame with reserved bits, 16-bit length and a mask key.
        send_byte({1'b0, 3'b111, OPC_BIN});
        send_byte({1'b1, LEN7_EXT16});
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'hFF);
        // Empty pong with a 64-bit length whose top bit is set.
        send_byte({1'b0, 3'b000, OPC_PONG});
        send_byte({1'b0, LEN7_EXT64});
        send_byte(8'h80);
        repeat (7) send_byte(8'h00);
        // The pong must not have replaced the remembered binary type.
        send_byte({1'b1, 3'b000, OPC_CONT});
        send_byte({1'b0, 7'd1});
        send_byte(8'h5A);

        for (int ph = 1; ph <= 3; ph++) begin
            if (ph == 2) begin
                send_idle_pct <= 59;
                recv_idle_pct <= 10;
            end else if (ph == 3) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                hold_armed    <= 1'b1;
            end
            while (sent_bytes < ph * BYTES_PER_PHASE) begin
                send_random_frame();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_buf.sv
hw/rtl/websocket_frame_deframer.sv
sim/wsd_stream_checker.sv
sim/websocket_frame_deframer_tb.sv
